FILE: src/ppc_pkg.sv
// shared types and constants of the pressure pump controller
// no dependencies

package ppc_pkg;

    localparam int TICKS_PER_SECOND = 61;

    // pressure = floor((adc * 1280 + PRESS_OFFSET) / 383) - PRESS_BIAS
    // the division is an exact reciprocal multiply over the whole adc range
    localparam logic [6:0]  PRESS_OFFSET = 7'd116;
    localparam logic [21:0] PRESS_RECIP  = 22'd2803504;
    localparam int          RECIP_SHIFT  = 30;
    localparam logic [12:0] PRESS_BIAS   = 13'd652;

    localparam logic [7:0]  LOW_WAIT_S   = 8'd10;
    localparam logic [7:0]  START_HOLD_S = 8'd10;
    localparam logic [15:0] UNDER_MIN_S  = 16'd30;
    localparam logic signed [13:0] BAND_Q8 = 14'sd128;

    localparam logic [1:0] REG_SETPOINT     = 2'd0;
    localparam logic [1:0] REG_MIN_PRESSURE = 2'd1;
    localparam logic [1:0] REG_RESTART      = 2'd2;

    typedef struct packed {
        logic [11:0] setpoint_q8;
        logic [11:0] min_pressure_q8;
        logic [15:0] restart_delay_s;
    } ppc_cfg_t;

    typedef struct packed {
        logic               tick;
        logic               level_fault;
        logic               dry_run_fault;
        logic signed [12:0] pressure_q8;
    } ppc_sample_t;

    typedef struct packed {
        logic               pump_drive;
        logic               level_led;
        logic               dry_led;
        logic signed [12:0] pressure_q8;
        logic               delay_active;
        logic [15:0]        delay_left_s;
    } ppc_result_t;

endpackage

FILE: src/pressure_pump_controller_top.sv
// pressure pump controller top level: stream ports, register port, pipeline
// depends on ppc_pkg, ppc_pressure, ppc_ctrl

// Takes one transaction per clock unless stalled and returns one result
// transaction for each through an input register, a register after the
// pressure multiply and the result register after the control state update.
// The pipeline moves whenever the result register is empty or being taken, so
// s_tready follows m_tready. Registers are written through cfg_we/cfg_index/
// cfg_data and should only change while no transaction is in flight.

module pressure_pump_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tick, adc_sample[9:0], level_fault, dry_run_fault, zero pad
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pump_drive, level_led, dry_led, pressure_q8[12:0], delay_active,
    // delay_left_s[15:0], zero pad
    output logic [39:0] m_tdata
);

    ppc_pkg::ppc_cfg_t    cfg_reg;
    ppc_pkg::ppc_sample_t smp_reg, smp_next;
    ppc_pkg::ppc_result_t res;

    logic        adv;
    logic        v1_reg, v2_reg, mv_reg;
    logic [15:0] in_reg;
    logic signed [12:0] pressure;

    assign adv      = !mv_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ppc_pkg::REG_SETPOINT:     cfg_reg.setpoint_q8 <= cfg_data[11:0];
                ppc_pkg::REG_MIN_PRESSURE: cfg_reg.min_pressure_q8 <= cfg_data[11:0];
                ppc_pkg::REG_RESTART:      cfg_reg.restart_delay_s <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            mv_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_tvalid) begin
            in_reg <= s_tdata;
        end
        if (adv && v1_reg) begin
            smp_reg <= smp_next;
        end
    end

    ppc_pressure u_pressure (
        .adc_sample  (in_reg[10:1]),
        .pressure_q8 (pressure)
    );

    always_comb begin
        smp_next.tick          = in_reg[0];
        smp_next.level_fault   = in_reg[11];
        smp_next.dry_run_fault = in_reg[12];
        smp_next.pressure_q8   = pressure;
    end

    ppc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv && v2_reg),
        .cfg     (cfg_reg),
        .smp     (smp_reg),
        .res     (res)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'b0, res.delay_left_s, res.delay_active, res.pressure_q8,
                       res.dry_led, res.level_led, res.pump_drive};

    // no remaining delay shown without an active delay
    a_delay_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[16] |-> m_tdata[32:17] == 16'd0)
        else $error("delay_left_s set while delay inactive");

    // a fault indication always means the pump is off
    a_led_pump: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1] || m_tdata[2]) |-> !m_tdata[0])
        else $error("pump on with fault indication");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

FILE: src/ppc_pressure.sv
// adc sample to q8 bar pressure by reciprocal multiply
// depends on ppc_pkg

module ppc_pressure (
    input  logic [9:0]         adc_sample,
    output logic signed [12:0] pressure_q8
);

    logic [20:0] scaled;
    logic [42:0] product;
    logic [12:0] quotient;

    assign scaled   = {1'b0, adc_sample, 10'b0} + {3'b0, adc_sample, 8'b0}
                      + {14'b0, ppc_pkg::PRESS_OFFSET};
    assign product  = {22'b0, scaled} * {21'b0, ppc_pkg::PRESS_RECIP};
    assign quotient = product[ppc_pkg::RECIP_SHIFT +: 13];
    assign pressure_q8 = $signed(quotient - ppc_pkg::PRESS_BIAS);

endmodule

FILE: src/ppc_ctrl.sv
// pump control state: second timers, fault cutoffs and result register
// depends on ppc_pkg

module ppc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  ppc_pkg::ppc_cfg_t     cfg,
    input  ppc_pkg::ppc_sample_t  smp,
    output ppc_pkg::ppc_result_t  res
);

    logic [5:0]  tc_reg, tc_next;
    logic        lwf_reg, lwf_next;
    logic [7:0]  lws_reg, lws_next;
    logic        shf_reg, shf_next;
    logic [7:0]  shs_reg, shs_next;
    logic        df_reg, df_next;
    logic [15:0] ds_reg, ds_next;
    logic        de_reg, de_next;
    logic        umf_reg, umf_next;
    logic [15:0] ums_reg, ums_next;
    logic        pr_reg, pr_next;
    ppc_pkg::ppc_result_t res_reg, res_next;

    logic signed [13:0] p_ext, sp_ext, mn_ext;
    logic p_lo, p_hi, p_under;

    assign p_ext   = {smp.pressure_q8[12], smp.pressure_q8};
    assign sp_ext  = $signed({2'b00, cfg.setpoint_q8});
    assign mn_ext  = $signed({2'b00, cfg.min_pressure_q8});
    assign p_lo    = (p_ext + ppc_pkg::BAND_Q8) < sp_ext;
    assign p_hi    = p_ext > (sp_ext + ppc_pkg::BAND_Q8);
    assign p_under = p_ext < mn_ext;

    always_comb begin
        tc_next  = tc_reg;
        lwf_next = lwf_reg;
        lws_next = lws_reg;
        shf_next = shf_reg;
        shs_next = shs_reg;
        df_next  = df_reg;
        ds_next  = ds_reg;
        de_next  = de_reg;
        umf_next = umf_reg;
        ums_next = ums_reg;
        pr_next  = pr_reg;
        res_next = '0;
        res_next.pressure_q8 = smp.pressure_q8;

        if (smp.tick) begin
            tc_next = tc_reg + 6'd1;
            if (tc_next == 6'(ppc_pkg::TICKS_PER_SECOND)) begin
                if (lwf_reg && lws_reg != 8'hFF) lws_next = lws_reg + 8'd1;
                if (shf_reg && shs_reg != 8'hFF) shs_next = shs_reg + 8'd1;
                if (df_reg && ds_reg != 16'hFFFF) ds_next = ds_reg + 16'd1;
                if (umf_reg && ums_reg != 16'hFFFF) ums_next = ums_reg + 16'd1;
                tc_next = '0;
            end
        end

        // fault cutoffs, ignored during start hold
        if (smp.level_fault && !shf_reg) begin
            pr_next = 1'b0;
            res_next.level_led = 1'b1;
        end
        if (smp.dry_run_fault && !shf_reg) begin
            pr_next = 1'b0;
            res_next.dry_led = 1'b1;
        end

        if (!shf_reg && !df_reg && p_lo) lwf_next = 1'b1;

        if (lws_next >= ppc_pkg::LOW_WAIT_S) begin
            lwf_next = 1'b0;
            lws_next = '0;
            if (p_lo && !smp.level_fault && !smp.dry_run_fault) begin
                pr_next  = 1'b1;
                de_next  = 1'b0;
                shf_next = 1'b1;
            end
        end

        if (shs_next >= ppc_pkg::START_HOLD_S) begin
            shf_next = 1'b0;
            shs_next = '0;
        end

        if (p_hi && !df_next && !de_next && !shf_next) begin
            pr_next = 1'b0;
            df_next = 1'b1;
        end

        res_next.delay_active = df_next;
        if (df_next && cfg.restart_delay_s > ds_next)
            res_next.delay_left_s = cfg.restart_delay_s - ds_next;

        if (ds_next >= cfg.restart_delay_s) begin
            df_next = 1'b0;
            ds_next = '0;
            de_next = 1'b1;
        end

        if (p_under && pr_next) umf_next = 1'b1;

        if (ums_next >= ppc_pkg::UNDER_MIN_S && pr_next && p_under) begin
            pr_next  = 1'b0;
            ums_next = '0;
            umf_next = 1'b0;
        end

        res_next.pump_drive = pr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg  <= '0;
            lwf_reg <= 1'b0;
            lws_reg <= '0;
            shf_reg <= 1'b0;
            shs_reg <= '0;
            df_reg  <= 1'b0;
            ds_reg  <= '0;
            de_reg  <= 1'b0;
            umf_reg <= 1'b0;
            ums_reg <= '0;
            pr_reg  <= 1'b0;
        end else if (en) begin
            tc_reg  <= tc_next;
            lwf_reg <= lwf_next;
            lws_reg <= lws_next;
            shf_reg <= shf_next;
            shs_reg <= shs_next;
            df_reg  <= df_next;
            ds_reg  <= ds_next;
            de_reg  <= de_next;
            umf_reg <= umf_next;
            ums_reg <= ums_next;
            pr_reg  <= pr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
